// ----- rtl/dbf_pkg.sv -----
// ----------------------------------------------------------------------------
// Duplicate box filter package
// Field widths, opcodes, register constants and the sequencer state type.
// ----------------------------------------------------------------------------
package dbf_pkg;

    localparam int TAG_W         = 32;
    localparam int FIELD_COORD_W = 20;
    localparam int CLASS_W       = 16;
    localparam int SCORE_W       = 16;
    localparam int LIMIT_W       = 42;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 42'd655;

    localparam logic OP_ROW   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

endpackage

// ----- rtl/duplicate_box_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Duplicate box filter unit
// Keeps a table of detection boxes, merges near-identical boxes by score and
// emits the table in insertion order on a flush.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// item      in         start high while busy low      opcode, tag, box, class, score
// result    out        o_result_valid, one cycle      entry fields, last, overflow
// config    in         i_cfg_valid and o_cfg_ready    distance limit
//
// A row compares the kept entries in turn and ends at the first match, after
// the last entry, or without any read on an empty table; the single table memory
// is read at most once per kept entry through a three-stage read, square and
// compare pipeline. A flush reads every kept entry and each of its results
// appears in the cycle after its read. Reset clears the table count, the
// overflow flag and the limit to its default. The receiver cannot stall
// results, so nothing here waits on it.
// ----------------------------------------------------------------------------
module duplicate_box_filter_unit
    import dbf_pkg::*;
#(
    parameter int MAX_ENTRIES = 32,
    parameter int COORD_BITS  = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_opcode,
    input  logic [TAG_W-1:0]         i_item_tag,
    input  logic [FIELD_COORD_W-1:0] i_box_left,
    input  logic [FIELD_COORD_W-1:0] i_box_top,
    input  logic [FIELD_COORD_W-1:0] i_box_right,
    input  logic [FIELD_COORD_W-1:0] i_box_bottom,
    input  logic [CLASS_W-1:0]       i_class_code,
    input  logic [SCORE_W-1:0]       i_score,
    output logic                     o_result_valid,
    output logic [TAG_W-1:0]         o_out_tag,
    output logic [FIELD_COORD_W-1:0] o_out_left,
    output logic [FIELD_COORD_W-1:0] o_out_top,
    output logic [FIELD_COORD_W-1:0] o_out_right,
    output logic [FIELD_COORD_W-1:0] o_out_bottom,
    output logic [CLASS_W-1:0]       o_out_class,
    output logic [SCORE_W-1:0]       o_out_score,
    output logic                     o_last_of_run,
    output logic                     o_overflow_seen,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LIMIT_W-1:0]       i_cfg_data
);

    localparam int AW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NW   = $clog2(MAX_ENTRIES + 1);
    localparam int KW   = (COORD_BITS < FIELD_COORD_W) ? COORD_BITS : FIELD_COORD_W;
    localparam int SQW  = 2 * COORD_BITS;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = (SUMW > LIMIT_W) ? SUMW : LIMIT_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_ENTRIES);

    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
        logic [CLASS_W-1:0]    cls;
        logic [SCORE_W-1:0]    score;
    } t_entry;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    t_entry                r_mem [MAX_ENTRIES];
    t_entry                r_rdata;
    t_entry                r_row;
    t_state                r_state;
    t_state                n_state;
    logic [LIMIT_W-1:0]    r_limit;
    logic [NW-1:0]         r_count;
    logic                  r_ovf;
    logic                  r_flush_ovf;
    logic [NW-1:0]         r_issue;
    logic                  r_s1_valid;
    logic [AW-1:0]         r_s1_idx;
    logic                  r_s1_last;
    logic                  r_s2_valid;
    logic [AW-1:0]         r_s2_idx;
    logic                  r_s2_last;
    logic [SCORE_W-1:0]    r_s2_kscore;
    logic [SQW-1:0]        r_sq [4];
    logic                  r_out_valid;
    logic                  r_out_last;

    logic                  accept;
    logic                  rd_en;
    logic                  issue_last;
    logic [SUMW-1:0]       dist_sum;
    logic                  hit;
    logic                  scan_done;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  do_append;
    logic                  do_drop;
    logic [COORD_BITS-1:0] d_left;
    logic [COORD_BITS-1:0] d_top;
    logic [COORD_BITS-1:0] d_right;
    logic [COORD_BITS-1:0] d_bottom;

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    assign rd_en      = ((r_state == ST_SCAN) || (r_state == ST_FLUSH)) && (r_issue < r_count);
    assign issue_last = ((r_issue + NW'(1)) == r_count);

    assign d_left   = abs_diff(r_rdata.left, r_row.left);
    assign d_top    = abs_diff(r_rdata.top, r_row.top);
    assign d_right  = abs_diff(r_rdata.right, r_row.right);
    assign d_bottom = abs_diff(r_rdata.bottom, r_row.bottom);

    assign dist_sum = SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]) + SUMW'(r_sq[3]);
    assign hit      = r_s2_valid && (CMPW'(dist_sum) < CMPW'(r_limit));

    always_comb begin
        wr_en     = 1'b0;
        wr_addr   = r_count[AW-1:0];
        do_append = 1'b0;
        do_drop   = 1'b0;
        scan_done = 1'b0;
        if (r_state == ST_SCAN) begin
            if (hit) begin
                scan_done = 1'b1;
                wr_en     = (r_row.score > r_s2_kscore);
                wr_addr   = r_s2_idx;
            end else if ((r_count == '0) || (r_s2_valid && r_s2_last)) begin
                scan_done = 1'b1;
                if (r_count != MAX_N) begin
                    do_append = 1'b1;
                    wr_en     = 1'b1;
                end else begin
                    do_drop = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_opcode == OP_ROW)) begin
                    n_state = ST_SCAN;
                end else if (accept && (i_opcode == OP_FLUSH) && (r_count != '0)) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (rd_en && issue_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_row;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_issue[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_opcode == OP_ROW)) begin
            r_row.tag    <= i_item_tag;
            r_row.left   <= COORD_BITS'(i_box_left[KW-1:0]);
            r_row.top    <= COORD_BITS'(i_box_top[KW-1:0]);
            r_row.right  <= COORD_BITS'(i_box_right[KW-1:0]);
            r_row.bottom <= COORD_BITS'(i_box_bottom[KW-1:0]);
            r_row.cls    <= i_class_code;
            r_row.score  <= i_score;
        end
        r_sq[0]     <= d_left * d_left;
        r_sq[1]     <= d_top * d_top;
        r_sq[2]     <= d_right * d_right;
        r_sq[3]     <= d_bottom * d_bottom;
        r_s1_idx    <= r_issue[AW-1:0];
        r_s1_last   <= issue_last;
        r_s2_idx    <= r_s1_idx;
        r_s2_last   <= r_s1_last;
        r_s2_kscore <= r_rdata.score;
        r_out_last  <= issue_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_flush_ovf <= 1'b0;
            r_issue     <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= rd_en && (r_state == ST_FLUSH);
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
            if (accept && (i_opcode == OP_FLUSH)) begin
                r_flush_ovf <= r_ovf;
                if (r_count == '0) begin
                    r_ovf <= 1'b0;
                end
            end
            if ((r_state == ST_SCAN) && scan_done) begin
                r_issue <= '0;
            end else if ((r_state == ST_FLUSH) && rd_en && issue_last) begin
                r_issue <= '0;
            end else if (rd_en) begin
                r_issue <= r_issue + NW'(1);
            end
            if (r_state == ST_SCAN) begin
                r_s1_valid <= rd_en && !scan_done;
                r_s2_valid <= r_s1_valid && !scan_done;
                if (do_append) begin
                    r_count <= r_count + NW'(1);
                end
                if (do_drop) begin
                    r_ovf <= 1'b1;
                end
            end else begin
                r_s1_valid <= 1'b0;
                r_s2_valid <= 1'b0;
            end
            if ((r_state == ST_FLUSH) && rd_en && issue_last) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    assign o_result_valid  = r_out_valid;
    assign o_out_tag       = r_rdata.tag;
    assign o_out_left      = FIELD_COORD_W'(r_rdata.left[KW-1:0]);
    assign o_out_top       = FIELD_COORD_W'(r_rdata.top[KW-1:0]);
    assign o_out_right     = FIELD_COORD_W'(r_rdata.right[KW-1:0]);
    assign o_out_bottom    = FIELD_COORD_W'(r_rdata.bottom[KW-1:0]);
    assign o_out_class     = r_rdata.cls;
    assign o_out_score     = r_rdata.score;
    assign o_last_of_run   = r_out_last;
    assign o_overflow_seen = r_flush_ovf;

endmodule

// ----- rtl/dbf_checker.sv -----
// ----------------------------------------------------------------------------
// Duplicate box filter checker
// Port-level checks on the result sequence of the duplicate box filter unit.
// ----------------------------------------------------------------------------
module dbf_checker
    import dbf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_opcode,
    input logic o_result_valid,
    input logic o_last_of_run
);

    // Results only ever follow a cycle in which the block was busy, as it is during a flush.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_valid)
        else $error("result in the cycle after an item was accepted");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_of_run) |=> o_result_valid)
        else $error("flush run broken before its last item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_last_of_run) |=> !o_result_valid)
        else $error("result after the last item of a flush run");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_ROW)) |=> busy)
        else $error("row accepted without the block going busy");

endmodule

bind duplicate_box_filter_unit dbf_checker u_dbf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_opcode       (i_opcode),
    .o_result_valid (o_result_valid),
    .o_last_of_run  (o_last_of_run)
);
